FILE: hdl/c2dvn_pkg.sv
// ----------------------------------------------------------------------------
// c2dvn_pkg: shared types and constants
// Register indexes, fixed field widths and the command and status bundles
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package c2dvn_pkg;

    localparam int CFG_W    = 64;
    localparam int CFG_IW   = 3;
    localparam int PIX_IN_W = 8;
    localparam int VALUE_W  = 21;
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 13;
    localparam int KSIZE_W  = 3;
    localparam int NUM_COEFS = 25;
    localparam int COEF_VEC_W = 8 * NUM_COEFS;

    localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IW-1:0] REG_KERNEL_SIZE  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_COEF_BANK_0  = 3'd3;
    localparam logic [CFG_IW-1:0] REG_COEF_BANK_1  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_COEF_BANK_2  = 3'd5;
    localparam logic [CFG_IW-1:0] REG_COEF_BANK_3  = 3'd6;
    localparam logic [CFG_IW-1:0] REG_NORMALIZE    = 3'd7;

    typedef struct packed {
        logic accept;
        logic tap_rd;
        logic tap_mac;
        logic div_load;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic valid_pos;
        logic last_tap;
        logic need_div;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

FILE: hdl/c2dvn_ram.sv
// ----------------------------------------------------------------------------
// c2dvn_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module c2dvn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/c2dvn_ctrl.sv
// ----------------------------------------------------------------------------
// c2dvn_ctrl: sequencing state machine
// Accepts a pixel, steps the window taps, runs the divider when needed and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module c2dvn_ctrl import c2dvn_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_MAC  = 3'd2;
    localparam logic [2:0] ST_PREP = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (sts.valid_pos) begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                cmd.tap_rd = 1'b1;
                state_next = ST_MAC;
            end
            ST_MAC: begin
                cmd.tap_mac = 1'b1;
                state_next  = sts.last_tap ? ST_PREP : ST_READ;
            end
            ST_PREP: begin
                cmd.div_load = 1'b1;
                state_next   = sts.need_div ? ST_DIV : ST_OUT;
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/c2dvn_dp.sv
// ----------------------------------------------------------------------------
// c2dvn_dp: convolution datapath
// Configuration registers, position counters, row store, one shared
// multiply-accumulate, a bit-serial divider and the output register.
// ----------------------------------------------------------------------------
module c2dvn_dp import c2dvn_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 5,
    parameter int PIXEL_BITS = 8,
    parameter int COEF_BITS  = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CFG_IW-1:0]   cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic [PIX_IN_W-1:0] pixel,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [VALUE_W-1:0]  m_value,
    output logic                m_flag,
    output logic                m_last
);

    localparam int CE    = (COEF_BITS < 8) ? COEF_BITS : 8;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int EWW   = $clog2(MAX_WIDTH + 1) + 1;
    localparam int SW    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int TAPS  = MAX_KERNEL * MAX_KERNEL;
    localparam int IW    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int ACC_W = PIXEL_BITS + CE + $clog2(TAPS) + 1;
    localparam int CSW   = CE + $clog2(TAPS) + 1;
    localparam int DCW   = $clog2(ACC_W + 1);
    localparam int DEPTH = 2 ** (SW + CW);

    // Configuration registers.
    logic [WIDTH_W-1:0]    width_reg;
    logic [HEIGHT_W-1:0]   height_reg;
    logic [KSIZE_W-1:0]    ksize_reg;
    logic [COEF_VEC_W-1:0] coef_reg;
    logic                  norm_reg;

    // Position counters.
    logic [CW-1:0]       col_reg;
    logic [HEIGHT_W-1:0] row_reg;
    logic [SW-1:0]       slot_reg;

    // Tap walk.
    logic [IW-1:0]      idx_reg;
    logic [KSIZE_W-1:0] tm_reg, tn_reg;
    logic [CW-1:0]      tc_reg, cbase_reg;
    logic [SW-1:0]      tr_reg;
    logic               last_reg;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [CSW-1:0]   csum_reg;

    // Divider.
    logic [ACC_W-1:0] quo_reg;
    logic [CSW-1:0]   rem_reg;
    logic [CSW-1:0]   dsr_reg;
    logic             neg_reg;
    logic [DCW-1:0]   dcnt_reg;

    logic                m_tvalid_reg;
    logic [VALUE_W-1:0]  m_value_reg;
    logic                m_flag_reg;
    logic                m_last_reg;

    // Effective geometry.
    logic [EWW-1:0]      eff_w;
    logic [HEIGHT_W:0]   eff_h;
    logic [KSIZE_W-1:0]  eff_k;
    logic                last_col, last_row;
    logic [KSIZE_W-1:0]  km1;

    always_comb begin
        if (width_reg == '0) begin
            eff_w = EWW'(1);
        end else if (EWW'(width_reg) > EWW'(MAX_WIDTH)) begin
            eff_w = EWW'(MAX_WIDTH);
        end else begin
            eff_w = EWW'(width_reg);
        end
        eff_h = (height_reg == '0) ? (HEIGHT_W+1)'(1) : (HEIGHT_W+1)'(height_reg);
        if (ksize_reg == '0) begin
            eff_k = KSIZE_W'(1);
        end else if (ksize_reg > KSIZE_W'(MAX_KERNEL)) begin
            eff_k = KSIZE_W'(MAX_KERNEL);
        end else begin
            eff_k = ksize_reg;
        end
    end

    assign km1      = eff_k - KSIZE_W'(1);
    assign last_col = (EWW'(col_reg) + EWW'(1)) >= eff_w;
    assign last_row = ((HEIGHT_W+1)'(row_reg) + (HEIGHT_W+1)'(1)) >= eff_h;

    assign sts.valid_pos = ((HEIGHT_W+1)'(row_reg) >= (HEIGHT_W+1)'(km1)) &&
                           (EWW'(col_reg) >= EWW'(km1));
    assign sts.last_tap  = (tm_reg == km1) && (tn_reg == km1);
    assign sts.need_div  = norm_reg && (csum_reg != '0);
    assign sts.div_done  = (dcnt_reg == '0);
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    // Starting window row in the row store, modulo MAX_KERNEL.
    logic [SW+1:0] tr_start_w;
    logic [SW-1:0] tr_start;
    assign tr_start_w = (SW+2)'(slot_reg) + (SW+2)'(MAX_KERNEL) - (SW+2)'(km1);
    assign tr_start   = (tr_start_w >= (SW+2)'(MAX_KERNEL)) ?
                        SW'(tr_start_w - (SW+2)'(MAX_KERNEL)) : SW'(tr_start_w);

    // Row store.
    logic [PIXEL_BITS-1:0] rd_pix;

    c2dvn_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (DEPTH)
    ) u_row_store (
        .aclk    (aclk),
        .wr_en   (cmd.accept),
        .wr_addr ({slot_reg, col_reg}),
        .wr_data (PIXEL_BITS'(pixel)),
        .rd_en   (cmd.tap_rd),
        .rd_addr ({tr_reg, tc_reg}),
        .rd_data (rd_pix)
    );

    // Coefficient of the current tap; indexes past the last bank read as zero.
    logic [7:0]            coef_byte;
    logic signed [CE-1:0]  coef_s;
    logic signed [CSW-1:0] coef_ext;
    logic signed [PIXEL_BITS+CE:0] prod;

    always_comb begin
        if (32'(idx_reg) < NUM_COEFS) begin
            coef_byte = coef_reg[8 * 32'(idx_reg) +: 8];
        end else begin
            coef_byte = 8'd0;
        end
        coef_s   = coef_byte[CE-1:0];
        coef_ext = CSW'(coef_s);
        prod     = $signed({1'b0, rd_pix}) * coef_s;
    end

    // Divider step and final values.
    logic [CSW:0]            rem_sh;
    logic [ACC_W-1:0]        acc_mag;
    logic [CSW-1:0]          csum_mag;
    logic signed [ACC_W-1:0] res;

    assign rem_sh   = {rem_reg, quo_reg[ACC_W-1]};
    assign acc_mag  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign csum_mag = csum_reg[CSW-1] ? CSW'(-csum_reg) : CSW'(csum_reg);
    assign res      = sts.need_div ? (neg_reg ? $signed(-quo_reg) : $signed(quo_reg))
                                   : acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= WIDTH_W'(1024);
            height_reg   <= HEIGHT_W'(768);
            ksize_reg    <= KSIZE_W'(3);
            coef_reg     <= '0;
            norm_reg     <= 1'b1;
            col_reg      <= '0;
            row_reg      <= '0;
            slot_reg     <= '0;
            dcnt_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_IMAGE_WIDTH: begin
                        width_reg <= cfg_wdata[WIDTH_W-1:0];
                        col_reg <= '0; row_reg <= '0; slot_reg <= '0;
                    end
                    REG_IMAGE_HEIGHT: begin
                        height_reg <= cfg_wdata[HEIGHT_W-1:0];
                        col_reg <= '0; row_reg <= '0; slot_reg <= '0;
                    end
                    REG_KERNEL_SIZE: begin
                        ksize_reg <= cfg_wdata[KSIZE_W-1:0];
                        col_reg <= '0; row_reg <= '0; slot_reg <= '0;
                    end
                    REG_COEF_BANK_0: coef_reg[63:0]    <= cfg_wdata;
                    REG_COEF_BANK_1: coef_reg[127:64]  <= cfg_wdata;
                    REG_COEF_BANK_2: coef_reg[191:128] <= cfg_wdata;
                    REG_COEF_BANK_3: coef_reg[199:192] <= cfg_wdata[7:0];
                    REG_NORMALIZE:   norm_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end

            if (cmd.accept) begin
                if (last_col) begin
                    col_reg <= '0;
                    if (last_row) begin
                        row_reg  <= '0;
                        slot_reg <= '0;
                    end else begin
                        row_reg  <= row_reg + HEIGHT_W'(1);
                        slot_reg <= (slot_reg == SW'(MAX_KERNEL - 1)) ? '0
                                                                     : slot_reg + SW'(1);
                    end
                end else begin
                    col_reg <= col_reg + CW'(1);
                end
            end

            if (cmd.div_load) begin
                dcnt_reg <= DCW'(ACC_W);
            end else if (cmd.div_step) begin
                dcnt_reg <= dcnt_reg - DCW'(1);
            end

            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            idx_reg   <= '0;
            tm_reg    <= '0;
            tn_reg    <= '0;
            tc_reg    <= col_reg - CW'(km1);
            cbase_reg <= col_reg - CW'(km1);
            tr_reg    <= tr_start;
            acc_reg   <= '0;
            csum_reg  <= '0;
            last_reg  <= last_col && last_row;
        end
        if (cmd.tap_mac) begin
            acc_reg  <= acc_reg + ACC_W'(prod);
            csum_reg <= csum_reg + coef_ext;
            idx_reg  <= idx_reg + IW'(1);
            if (tn_reg == km1) begin
                tn_reg <= '0;
                tm_reg <= tm_reg + KSIZE_W'(1);
                tc_reg <= cbase_reg;
                tr_reg <= (tr_reg == SW'(MAX_KERNEL - 1)) ? '0 : tr_reg + SW'(1);
            end else begin
                tn_reg <= tn_reg + KSIZE_W'(1);
                tc_reg <= tc_reg + CW'(1);
            end
        end
        if (cmd.div_load) begin
            quo_reg <= acc_mag;
            rem_reg <= '0;
            dsr_reg <= csum_mag;
            neg_reg <= acc_reg[ACC_W-1] ^ csum_reg[CSW-1];
        end else if (cmd.div_step) begin
            if (rem_sh >= {1'b0, dsr_reg}) begin
                rem_reg <= CSW'(rem_sh - {1'b0, dsr_reg});
                quo_reg <= {quo_reg[ACC_W-2:0], 1'b1};
            end else begin
                rem_reg <= CSW'(rem_sh);
                quo_reg <= {quo_reg[ACC_W-2:0], 1'b0};
            end
        end
        if (cmd.out_load) begin
            m_value_reg <= VALUE_W'(res);
            m_flag_reg  <= norm_reg && (csum_reg == '0);
            m_last_reg  <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_value  = m_value_reg;
    assign m_flag   = m_flag_reg;
    assign m_last   = m_last_reg;

endmodule

FILE: hdl/conv2d_valid_normalized_top.sv
// ----------------------------------------------------------------------------
// conv2d_valid_normalized_top: streaming k x k valid convolution
// Raster-order pixels in, one convolution result per valid window position
// out, normalized by the coefficient sum when that is enabled and nonzero.
// ----------------------------------------------------------------------------
// A pixel at a position with no complete window is only stored. A pixel
// that completes a window starts a walk over the k*k window taps and, when
// the sum is divided, a run of the divider over ACC_W quotient bits (ACC_W =
// PIXEL_BITS + min(COEF_BITS,8) + clog2(MAX_KERNEL^2) + 1, which is 22 at the
// defaults). The single shared multiply-accumulate reads one window tap at a
// time from the row store, and the divider retires one quotient bit per cycle.
// The result waits in an output register, and a new pixel is taken while it
// waits. The row store needs no clearing after reset.
module conv2d_valid_normalized_top import c2dvn_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 5,
    parameter int PIXEL_BITS = 8,
    parameter int COEF_BITS  = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] pixel
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // [20:0] value, [23:21] zero
    output logic              m_tuser,   // [0] zero_sum_flag
    output logic              m_tlast
);

    cmd_t               cmd;
    sts_t               sts;
    logic [VALUE_W-1:0] value;

    c2dvn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    c2dvn_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_KERNEL (MAX_KERNEL),
        .PIXEL_BITS (PIXEL_BITS),
        .COEF_BITS  (COEF_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .pixel     (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_value   (value),
        .m_flag    (m_tuser),
        .m_last    (m_tlast)
    );

    assign m_tdata = {3'b000, value};

endmodule
